FILE: src/cpsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpsp_pkg
// shared types, constants and helpers of the cascaded position/speed stepper core
// ----------------------------------------------------------------------------
package cpsp_pkg;

	localparam int IN_W    = 128;
	localparam int OUT_W   = 56;
	localparam int CFG_IW  = 4;
	localparam int WIDE_W  = 67;
	localparam int MIN_HALF = 30;

	typedef enum logic [3:0] {
		REG_POS_P   = 4'd0,
		REG_POS_I   = 4'd1,
		REG_POS_D   = 4'd2,
		REG_VEL_P   = 4'd3,
		REG_VEL_I   = 4'd4,
		REG_VEL_D   = 4'd5,
		REG_MAX_SPD = 4'd6,
		REG_PER_NUM = 4'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAMP,
		ST_PMUL,
		ST_PPOST,
		ST_VERR,
		ST_VMUL,
		ST_ACC,
		ST_LIM,
		ST_STALL,
		ST_DIV,
		ST_WDIV,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quot;
	} div_rsp_t;

	// saturate a wide signed value to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic [31:0] r;
		if (v > WIDE_W'(64'sh7FFF_FFFF)) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -WIDE_W'(64'sh8000_0000)) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/cpsp_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpsp_mul
// registered unsigned-gain by signed-error multiplier shared by both loops
// ----------------------------------------------------------------------------
module cpsp_mul (
	input  wire logic               clk,
	input  wire logic [31:0]        gain,
	input  wire logic signed [31:0] err,
	output logic signed [64:0]      prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= $signed({1'b0, gain}) * err;
	end
endmodule
`default_nettype wire

FILE: src/cpsp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpsp_div
// radix-2 restoring divider, quotient saturated to 16 bits
// ----------------------------------------------------------------------------
module cpsp_div #(
	parameter int NUM_W = 48
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [31:0]      den,
	output cpsp_pkg::div_rsp_t    rsp
);
	import cpsp_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [32:0] rem_q;
	logic [15:0] lo_q;
	logic [15:0] quot_q;
	logic [33:0] trial;
	logic        sat;

	// quotient overflows 16 bits exactly when num >= den * 2^16
	assign sat   = {{(64-NUM_W){1'b0}}, num} >= {16'd0, den, 16'd0};
	assign trial = {rem_q, lo_q[15]} - {2'b00, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (sat) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 5'd16;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= 33'(num >> 16);
			lo_q   <= num[15:0];
			quot_q <= sat ? 16'hFFFF : 16'd0;
		end else if (busy_q) begin
			lo_q <= {lo_q[14:0], 1'b0};
			if (!trial[33]) begin
				rem_q  <= trial[32:0];
				quot_q <= {quot_q[14:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[31:0], lo_q[15]};
				quot_q <= {quot_q[14:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
endmodule
`default_nettype wire

FILE: src/cascaded_position_speed_pid_stepper_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cascaded_position_speed_pid_stepper_core
// cascaded incremental position and speed pid producing a step timer setting
// ----------------------------------------------------------------------------
// usage
//   s_* stream: one transaction per sample tick carrying commanded speed,
//   target position, measured position and measured speed
//   m_* stream: one transaction per input with direction, drive enable,
//   timer half period and the accumulated speed command
//   cfg_*: register writes (gains, max speed, period numerator), always ready,
//   only to be used while the core is idle
// sequencing
//   one item at a time; m_tvalid rises once the position loop, speed loop and
//   a full 16-step restoring divide are through (six products through one
//   shared multiplier), sooner with a zero ramp, when the speed command is not
//   positive or when the period saturates, and stays high while the receiver
//   holds m_tready low; s_tready returns the cycle after the result transaction
// reset
//   arst_n clears loop state, ramp returns to 5.0, registers go to defaults
// stall
//   the result is held in the output register until m_tready is seen
// ----------------------------------------------------------------------------
module cascaded_position_speed_pid_stepper_core #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// commanded_speed[30:0], target_position[62:31], measured_position[94:63],
	// measured_speed[126:95]
	input  wire logic [cpsp_pkg::IN_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// direction[0], drive_enable[1], half_period[17:2], speed_command[49:18]
	output logic [cpsp_pkg::OUT_W-1:0]        m_tdata,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [cpsp_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [31:0]                  cfg_data
);
	import cpsp_pkg::*;

	localparam int NUM_W = 32 + FRAC_BITS;
	localparam logic signed [31:0] ONE_Q   = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] HALF_Q  = 32'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [31:0] DB_Q    = 32'((((64'd8) << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic signed [31:0] LOW_Q   = 32'((((64'd1) << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [31:0]        START_Q = 32'd5 << FRAC_BITS;

	// configuration registers
	logic [31:0] pkp_q, pki_q, pkd_q, vkp_q, vki_q, vkd_q, pnum_q;
	logic [15:0] maxspd_q;

	// loop state
	logic [31:0] ramp_q;
	logic [31:0] acc_q;
	logic [31:0] pel_q, pep_q, vel_q, vep_q;

	// working registers of one item
	st_t         st_q, st_d;
	logic [30:0] cmd_q;
	logic [31:0] tgt_q, pos_q, spd_q;
	logic [30:0] msf_q;
	logic [31:0] perr_q, verr_q, magc_q;
	logic [WIDE_W-1:0] sum_q;
	logic [1:0]  cnt_q;
	logic        dir_q, en_q;
	logic [15:0] half_q;

	// sequencer outputs
	logic        div_start;
	logic        vloop;

	// shared multiplier
	logic [31:0]        mul_gain;
	logic signed [31:0] mul_err;
	logic signed [64:0] prod_q;
	div_rsp_t           div_rsp;

	// combinational helpers
	logic signed [32:0]       rdiff;
	logic signed [32:0]       pdiff;
	logic [31:0]              perr_sat;
	logic signed [WIDE_W-1:0] term;
	logic signed [WIDE_W-1:0] pabs;
	logic [WIDE_W-1:0]        magt;
	logic [31:0]              magc;
	logic signed [WIDE_W-1:0] vdiff;
	logic [31:0]              verr_sat;
	logic [31:0]              acc_sat;
	logic [WIDE_W-1:0]        maxq;
	logic [WIDE_W-1:0]        stall_lim;
	logic [34:0]              msf5;
	logic [15:0]              per_half;

	function automatic logic [31:0] deadband(input logic [31:0] e);
		logic [31:0] r;
		if ($signed(e) < DB_Q && $signed(e) > -DB_Q) begin
			r = '0;
		end else begin
			r = e;
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkp_q    <= 32'd6554;
			pki_q    <= 32'd328;
			pkd_q    <= 32'd328;
			vkp_q    <= 32'd7864;
			vki_q    <= 32'd655;
			vkd_q    <= 32'd3277;
			maxspd_q <= 16'd1000;
			pnum_q   <= 32'd1000000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POS_P:   pkp_q    <= cfg_data;
				REG_POS_I:   pki_q    <= cfg_data;
				REG_POS_D:   pkd_q    <= cfg_data;
				REG_VEL_P:   vkp_q    <= cfg_data;
				REG_VEL_I:   vki_q    <= cfg_data;
				REG_VEL_D:   vkd_q    <= cfg_data;
				REG_MAX_SPD: maxspd_q <= cfg_data[15:0];
				REG_PER_NUM: pnum_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (s_tvalid) st_d = ST_RAMP;
			ST_RAMP:  st_d = ST_PMUL;
			ST_PMUL:  if (cnt_q == 2'd3) st_d = ST_PPOST;
			ST_PPOST: st_d = (ramp_q != 32'd0) ? ST_VERR : ST_OUT;
			ST_VERR:  st_d = ST_VMUL;
			ST_VMUL:  if (cnt_q == 2'd3) st_d = ST_ACC;
			ST_ACC:   st_d = ST_LIM;
			ST_LIM:   st_d = ST_STALL;
			ST_STALL: st_d = ST_DIV;
			ST_DIV:   st_d = ($signed(acc_q) > 32'sd0) ? ST_WDIV : ST_OUT;
			ST_WDIV:  if (div_rsp.done) st_d = ST_OUT;
			ST_OUT:   if (m_tready) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = (st_q == ST_IDLE);
		m_tvalid  = (st_q == ST_OUT);
		vloop     = (st_q == ST_VMUL);
		div_start = (st_q == ST_DIV) && ($signed(acc_q) > 32'sd0);
	end

	// operand select: current, previous and two-back error with their gains
	always_comb begin
		case (cnt_q)
			2'd0: begin
				mul_gain = vloop ? vkp_q : pkp_q;
				mul_err  = vloop ? verr_q : perr_q;
			end
			2'd1: begin
				mul_gain = vloop ? vki_q : pki_q;
				mul_err  = vloop ? vel_q : pel_q;
			end
			default: begin
				mul_gain = vloop ? vkd_q : pkd_q;
				mul_err  = vloop ? vep_q : pep_q;
			end
		endcase
	end

	cpsp_mul u_mul (
		.clk    (clk),
		.gain   (mul_gain),
		.err    (mul_err),
		.prod_q (prod_q)
	);

	cpsp_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({pnum_q, {FRAC_BITS{1'b0}}}),
		.den    (acc_q),
		.rsp    (div_rsp)
	);

	always_comb begin
		rdiff    = $signed({2'b00, cmd_q}) - $signed({1'b0, ramp_q});
		pdiff    = $signed({tgt_q[31], tgt_q}) - $signed({pos_q[31], pos_q});
		perr_sat = sat32(WIDE_W'(pdiff) <<< FRAC_BITS);
		// floor shift of the product is an arithmetic shift
		term     = WIDE_W'(prod_q >>> FRAC_BITS);
		pabs     = $signed(sum_q) < 0 ? -$signed(sum_q) : $signed(sum_q);
		magt     = pabs & ~((WIDE_W'(1) << FRAC_BITS) - WIDE_W'(1));
		magc     = (magt >= {{(WIDE_W-32){1'b0}}, ramp_q}) ? ramp_q : magt[31:0];
		vdiff    = $signed({{(WIDE_W-32){1'b0}}, magc_q})
			- $signed({{(WIDE_W-31){1'b0}}, msf_q} << FRAC_BITS);
		verr_sat = sat32(vdiff);
		acc_sat  = sat32($signed(WIDE_W'($signed(acc_q))) + $signed(sum_q));
		maxq     = {{(WIDE_W-16){1'b0}}, maxspd_q} << FRAC_BITS;
		msf5     = ({4'd0, msf_q} + 35'd1) + (({4'd0, msf_q} + 35'd1) << 2);
		stall_lim = {{(WIDE_W-35){1'b0}}, msf5} << FRAC_BITS;
		per_half = {1'b0, div_rsp.quot[15:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			cnt_q  <= '0;
			ramp_q <= START_Q;
			acc_q  <= '0;
			pel_q  <= '0;
			pep_q  <= '0;
			vel_q  <= '0;
			vep_q  <= '0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				ST_RAMP: begin
					// slew toward the command by at most one half per tick
					if (rdiff > $signed({1'b0, HALF_Q})) begin
						ramp_q <= ramp_q + HALF_Q;
					end else if (rdiff < -$signed({1'b0, HALF_Q})) begin
						ramp_q <= ramp_q - HALF_Q;
					end else begin
						ramp_q <= {1'b0, cmd_q};
					end
					cnt_q <= '0;
				end
				ST_PMUL, ST_VMUL: begin
					cnt_q <= (cnt_q == 2'd3) ? 2'd0 : cnt_q + 2'd1;
				end
				ST_PPOST: begin
					pep_q <= pel_q;
					pel_q <= perr_q;
				end
				ST_ACC: begin
					acc_q <= acc_sat;
					vep_q <= vel_q;
					vel_q <= verr_q;
				end
				ST_LIM: begin
					if ($signed(acc_q) <= LOW_Q) begin
						ramp_q <= START_Q;
					end else if ({{(WIDE_W-32){1'b0}}, acc_q} > maxq) begin
						acc_q <= maxq[31:0];
					end
				end
				ST_STALL: begin
					// commanded far above what the encoder sees: fall back to one
					if (!acc_q[31] && {{(WIDE_W-32){1'b0}}, acc_q} > stall_lim) begin
						acc_q <= ONE_Q;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				cmd_q <= s_tdata[30:0];
				tgt_q <= s_tdata[62:31];
				pos_q <= s_tdata[94:63];
				spd_q <= s_tdata[126:95];
			end
			ST_RAMP: begin
				// magnitude of the measured speed, most negative saturates
				if (spd_q == 32'h8000_0000) begin
					msf_q <= 31'h7FFF_FFFF;
				end else if (spd_q[31]) begin
					msf_q <= 31'(-spd_q);
				end else begin
					msf_q <= spd_q[30:0];
				end
				perr_q <= deadband(perr_sat);
				sum_q  <= '0;
				en_q   <= 1'b0;
				half_q <= '0;
			end
			ST_PMUL, ST_VMUL: begin
				// the registered product of the previous issue is added here, the second one subtracted
				if (cnt_q == 2'd2) begin
					sum_q <= sum_q - term;
				end else if (cnt_q != 2'd0) begin
					sum_q <= sum_q + term;
				end
			end
			ST_PPOST: begin
				dir_q  <= sum_q[WIDE_W-1];
				magc_q <= magc;
			end
			ST_VERR: begin
				verr_q <= deadband(verr_sat);
				sum_q  <= '0;
			end
			ST_WDIV: begin
				if (div_rsp.done) begin
					en_q   <= 1'b1;
					half_q <= (per_half < 16'(MIN_HALF)) ? 16'(MIN_HALF) : per_half;
				end
			end
			default: ;
		endcase
	end

	assign m_tdata = {6'd0, acc_q, half_q, en_q, dir_q};
endmodule
`default_nettype wire

FILE: src/cpsp_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpsp_chk
// port level checks of the stepper core
// ----------------------------------------------------------------------------
module cpsp_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_tvalid,
	input wire logic                      s_tready,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [cpsp_pkg::OUT_W-1:0] m_tdata
);
	import cpsp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result waits");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !m_tvalid)
		else $error("core not busy after accepting an item");

	a_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[17:2] == 16'd0)
		else $error("half period nonzero with drive off");

	a_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[17:2] >= 16'(MIN_HALF))
		else $error("half period below minimum");
endmodule

bind cascaded_position_speed_pid_stepper_core cpsp_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
